### sv/button_debounce_short_long_press_assert.svh
// ----------------------------------------------------------------------------
// Button debounce assertion macros
// Shared assertion forms for the button debounce checker.
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_SHORT_LONG_PRESS_ASSERT_SVH
`define BUTTON_DEBOUNCE_SHORT_LONG_PRESS_ASSERT_SVH

// Property checked only while out of reset
`define BDSL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included
`define BDSL_ASSERT_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/bdsl_pkg.sv
// ----------------------------------------------------------------------------
// Button debounce package
// Widths, register indexes, reset values and shared types.
// ----------------------------------------------------------------------------
package bdsl_pkg;

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned REG_W    = 16;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned IN_TDATA_W = 40;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 8'd1;

  // Register reset values
  localparam logic [REG_W-1:0] DEBOUNCE_RST   = 16'd50;
  localparam logic [REG_W-1:0] LONG_PRESS_RST = 16'd600;

  // Event kinds
  localparam logic EV_SHORT = 1'b0;
  localparam logic EV_LONG  = 1'b1;

  typedef struct packed {
    logic [REG_W-1:0] settle_ms;
    logic [REG_W-1:0] long_hold_ms;
  } cfg_regs_t;

  typedef struct packed {
    logic              valid;
    logic              kind;
    logic [TIME_W-1:0] time_ms;
  } event_t;

endpackage

### sv/button_debounce_short_long_press.sv
// ----------------------------------------------------------------------------
// Button debounce with short and long press
// Debounces polled button samples and reports short and long press events.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one poll word per transfer, tdata = {now_ms, raw_pressed}.
//   out_* : one event word, tdata = event_time, tuser = event_kind
//           (0 short press on release, 1 long press while held).
//   cfg_* : register writes, index 0 settle time, index 1 long-press time;
//           cfg_ready is always high, write only while the block is idle.
// Pipeline: an accepted poll is held in the input register; its event word
//   is loaded into the result register once that register is free or being
//   taken, and is then offered on out_*. Throughput is one poll per cycle
//   while out_* is not stalled; a poll that gives no event produces no output word.
// The settle check, the state update and the long-press check are all
//   combinational between the input and result registers.
// Reset: clears the button state and both pipeline registers, and loads
//   a 50 ms settle time and a 600 ms long-press time.
// Stall: while out_tready is low a pending event holds; one more poll can
//   sit in the input register, then in_tready drops.
// ----------------------------------------------------------------------------
module button_debounce_short_long_press
  import bdsl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Poll channel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,   // [0] raw_pressed, [32:1] now_ms, rest zero
  // Event channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [TIME_W-1:0]     out_tdata,  // [31:0] event_time
  output logic                  out_tuser,  // [0] event_kind
  // Configuration channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [REG_W-1:0]      cfg_data
);

  logic              in_v_r, in_v_nxt;
  logic              in_raw_r;
  logic [TIME_W-1:0] in_now_r;
  logic              out_v_r, out_v_nxt;
  logic              out_kind_r;
  logic [TIME_W-1:0] out_time_r;
  logic              advance;
  logic              in_take;
  cfg_regs_t         regs;
  event_t            evt;

  assign cfg_ready = 1'b1;

  bdsl_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  // Advance the held poll when the result register is free
  assign advance   = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || advance;
  assign in_take   = in_tvalid && in_tready;
  assign in_v_nxt  = in_take ? 1'b1 : (advance ? 1'b0 : in_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
  end

  // Capture the poll word
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_raw_r <= in_tdata[0];
      in_now_r <= in_tdata[TIME_W:1];
    end
  end

  bdsl_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .raw   (in_raw_r),
    .now   (in_now_r),
    .regs  (regs),
    .evt   (evt)
  );

  // Load a new event or drop the taken one
  assign out_v_nxt = advance ? evt.valid : (out_tready ? 1'b0 : out_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && evt.valid) begin
      out_kind_r <= evt.kind;
      out_time_r <= evt.time_ms;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_time_r;
  assign out_tuser  = out_kind_r;

endmodule

### sv/bdsl_cfg.sv
// ----------------------------------------------------------------------------
// Button debounce configuration registers
// Holds the debounce and long-press times, written through the cfg channel.
// ----------------------------------------------------------------------------
module bdsl_cfg
  import bdsl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data,
  output cfg_regs_t            regs
);

  cfg_regs_t regs_r;
  cfg_regs_t regs_nxt;

  // Decode the register index; unknown indexes are dropped
  always_comb begin
    regs_nxt = regs_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_DEBOUNCE:   regs_nxt.settle_ms    = cfg_data;
        CFG_LONG_PRESS: regs_nxt.long_hold_ms = cfg_data;
        default:        regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.settle_ms    <= DEBOUNCE_RST;
      regs_r.long_hold_ms <= LONG_PRESS_RST;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign regs = regs_r;

endmodule

### sv/bdsl_core.sv
// ----------------------------------------------------------------------------
// Button debounce core
// Button state registers and the per-poll settle and press-timing logic.
// ----------------------------------------------------------------------------
module bdsl_core
  import bdsl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic              raw,
  input  logic [TIME_W-1:0] now,
  input  cfg_regs_t         regs,
  output event_t            evt
);

  logic              stable_r, stable_nxt;
  logic              last_raw_r, last_raw_nxt;
  logic [TIME_W-1:0] raw_chg_time_r, raw_chg_time_nxt;
  logic [TIME_W-1:0] press_start_r, press_start_nxt;
  logic              long_rep_r, long_rep_nxt;

  logic              raw_chg;
  logic [TIME_W-1:0] settle_elapsed;
  logic              settled;
  logic              upd;
  logic              press;
  logic              release_ev;
  logic              long_mid;
  logic [TIME_W-1:0] held;
  logic              short_ev;
  logic              long_ev;

  // Settle check: a fresh raw change has zero elapsed time
  assign raw_chg        = raw != last_raw_r;
  assign settle_elapsed = now - raw_chg_time_r;
  assign settled        = raw_chg ? (regs.settle_ms == '0) :
                          (settle_elapsed >= {{(TIME_W-REG_W){1'b0}}, regs.settle_ms});
  assign upd            = settled && (stable_r != raw);
  assign press          = upd && raw;
  assign release_ev     = upd && !raw;

  // Press timing: a press taken this poll has zero hold time
  assign long_mid = press ? 1'b0 : long_rep_r;
  assign held     = press ? '0 : (now - press_start_r);
  assign short_ev = release_ev && !long_rep_r;
  assign long_ev  = (upd ? raw : stable_r) && !long_mid &&
                    (held >= {{(TIME_W-REG_W){1'b0}}, regs.long_hold_ms});

  // Next state
  assign stable_nxt       = upd ? raw : stable_r;
  assign last_raw_nxt     = raw;
  assign raw_chg_time_nxt = raw_chg ? now : raw_chg_time_r;
  assign press_start_nxt  = press ? now : press_start_r;
  assign long_rep_nxt     = long_ev ? 1'b1 : long_mid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r       <= 1'b0;
      last_raw_r     <= 1'b0;
      raw_chg_time_r <= '0;
      press_start_r  <= '0;
      long_rep_r     <= 1'b0;
    end else if (step) begin
      stable_r       <= stable_nxt;
      last_raw_r     <= last_raw_nxt;
      raw_chg_time_r <= raw_chg_time_nxt;
      press_start_r  <= press_start_nxt;
      long_rep_r     <= long_rep_nxt;
    end
  end

  assign evt.valid   = step && (short_ev || long_ev);
  assign evt.kind    = long_ev ? EV_LONG : EV_SHORT;
  assign evt.time_ms = now;

endmodule

### sv/bdsl_checker.sv
// ----------------------------------------------------------------------------
// Button debounce port checker
// Watches the top-level ports for handshake and flow-control slips.
// ----------------------------------------------------------------------------
`include "button_debounce_short_long_press_assert.svh"

module bdsl_checker
  import bdsl_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [TIME_W-1:0] out_tdata,
  input logic              out_tuser
);

  // A stalled event word stays offered
  `BDSL_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid, "event word dropped")

  // A stalled event word keeps its contents
  `BDSL_ASSERT(a_out_stable, out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser), "event word changed")

  // Poll input only backs up behind a stalled event
  `BDSL_ASSERT(a_in_backpressure, !in_tready |-> out_tvalid && !out_tready, "poll stalled without cause")

  // Reset leaves no event pending
  `BDSL_ASSERT_ALL(a_reset_empty, !rst_n |=> !out_tvalid, "event pending after reset")

endmodule

bind button_debounce_short_long_press bdsl_checker u_bdsl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
